// ----- hdl/att_pkg.sv -----
// Shared types, constants and register reset values of the tempo tracker.
package att_pkg;

	// Default sizes handed to the top level.
	localparam int MAX_WINDOW_DEF  = 1024;
	localparam int MAX_LAG_DEF     = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int ODF_W      = 16;
	localparam int WEIGHT_W   = 16;
	localparam int WIDX_W     = 8;
	localparam int WEIGHT_DEPTH = 256;
	localparam int TEMPO_W    = 16;
	localparam int CONF_W     = 9;
	localparam int PERIOD_W   = 25;
	localparam int NORM_W     = 18;
	localparam int SCORE_W    = NORM_W + WEIGHT_W + 1;
	localparam int ES_LIMIT_W = 40;

	// Shared divider sizes.
	localparam int DIV_NUM_W = 56;
	localparam int DIV_DEN_W = 41;

	// Register reset values.
	localparam logic [10:0] WINDOW_HOPS_RST = 11'd512;
	localparam logic [8:0]  MIN_LAG_RST     = 9'd24;
	localparam logic [8:0]  MAX_LAG_RST     = 9'd129;
	localparam logic [31:0] BPM_NUM_RST     = 32'd338690048;
	localparam logic [15:0] ALPHA_RST       = 16'd65031;

	typedef enum logic [1:0] {
		PASS_SUM,
		PASS_ENERGY,
		PASS_CORR
	} pass_kind_t;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_NORM,
		DIV_TEMPO
	} div_sel_t;

	typedef struct packed {
		logic [10:0] window_hops;
		logic [8:0]  min_lag;
		logic [8:0]  max_lag;
		logic [31:0] bpm_numerator;
		logic [15:0] smoothing_alpha;
	} cfg_t;

	typedef struct packed {
		logic       accept_sample;
		logic       write_weight;
		logic       pass_start;
		pass_kind_t kind;
		logic       div_start;
		div_sel_t   div_sel;
		logic       latch_mean;
		logic       energy_init;
		logic       shift_step;
		logic       lag_init;
		logic       latch_norm;
		logic       score_mul;
		logic       compare_step;
		logic       smooth1;
		logic       smooth2;
		logic       tempo_zero;
		logic       latch_tempo;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic short_win;
		logic pass_done;
		logic div_done;
		logic energy_zero;
		logic shift_done;
		logic lag_empty;
		logic tempo_ok;
	} status_t;

endpackage

// ----- hdl/att_divider.sv -----
// Restoring divider that yields one quotient bit per cycle.
module att_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [att_pkg::DIV_NUM_W-1:0]  num,
	input  logic [att_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [att_pkg::DIV_NUM_W-1:0]  quot
);
	localparam int NW = att_pkg::DIV_NUM_W;
	localparam int DW = att_pkg::DIV_DEN_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             ge;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Control: busy while bits remain, done until the next start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operands and partial remainder; the quotient shifts into num_q.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- hdl/att_datapath.sv -----
// Datapath of the tempo tracker: sample window, correlation passes and smoothing.
module att_datapath #(
	parameter int MAX_WINDOW  = att_pkg::MAX_WINDOW_DEF,
	parameter int MAX_LAG     = att_pkg::MAX_LAG_DEF,
	parameter int SAMPLE_BITS = att_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  att_pkg::cfg_t                 cfg,
	input  att_pkg::cmd_t                 cmd,
	output att_pkg::status_t              sts,
	input  logic [att_pkg::ODF_W-1:0]     odf_sample,
	input  logic [att_pkg::WIDX_W-1:0]    weight_index,
	input  logic [att_pkg::WEIGHT_W-1:0]  weight_value,
	output logic [att_pkg::TEMPO_W-1:0]   tempo_bpm,
	output logic [att_pkg::CONF_W-1:0]    confidence,
	output logic                          fresh
);
	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int CW    = $clog2(MAX_WINDOW + 1);
	localparam int LW    = $clog2(MAX_LAG + 1) + 1;
	localparam int SB    = SAMPLE_BITS;
	localparam int DVW   = SB + 1;
	localparam int PW    = 2 * DVW;
	localparam int ACC_W = PW + CW;
	localparam int MAGW  = ((ACC_W > att_pkg::ES_LIMIT_W) ? ACC_W : att_pkg::ES_LIMIT_W) + 1;
	localparam int SHW   = 7;
	localparam int ESW   = att_pkg::ES_LIMIT_W;
	localparam int NUMW  = att_pkg::DIV_NUM_W;
	localparam int DENW  = att_pkg::DIV_DEN_W;
	localparam int PERW  = att_pkg::PERIOD_W;
	localparam logic [PERW-1:0] PERIOD_MAX = '1;
	localparam int LAG_SAT = (1 << (PERW - 16)) - 1;

	// Storage.
	logic [SB-1:0]                  win_mem [MAX_WINDOW];
	logic [att_pkg::WEIGHT_W-1:0]   wt_mem  [att_pkg::WEIGHT_DEPTH];

	// Window bookkeeping.
	logic [AW-1:0] wp_q;
	logic [CW-1:0] fill_q;

	// Streaming pass.
	logic [CW-1:0]              iss_cnt_q;
	logic [CW-1:0]              len_q;
	logic [AW-1:0]              ptr_a_q;
	logic [AW-1:0]              ptr_b_q;
	att_pkg::pass_kind_t        kind_q;
	logic                       v_s1_q;
	logic                       v_s2_q;
	logic [SB-1:0]              rd_a_s1;
	logic [SB-1:0]              rd_b_s1;
	logic signed [PW-1:0]       prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// Statistics and lag search.
	logic [SB-1:0]                  mean_q;
	logic [MAGW-1:0]                es_q;
	logic [SHW-1:0]                 sh_q;
	logic [LW-1:0]                  lag_q;
	logic [LW-1:0]                  best_lag_q;
	logic signed [att_pkg::NORM_W-1:0]  norm_q;
	logic signed [att_pkg::NORM_W-1:0]  best_norm_q;
	logic signed [att_pkg::SCORE_W-1:0] score_q;
	logic signed [att_pkg::SCORE_W-1:0] best_score_q;
	logic                           have_best_q;
	logic [att_pkg::WEIGHT_W-1:0]   wt_q;

	// Period and results.
	logic [PERW-1:0]               period_q;
	logic                          have_period_q;
	logic                          fresh_q;
	logic                          pend_q;
	logic [PERW+15:0]              mul1_q;
	logic [PERW+16:0]              mul2_q;
	logic [att_pkg::TEMPO_W-1:0]   tempo_res_q;
	logic [att_pkg::TEMPO_W-1:0]   tempo_o_q;
	logic [att_pkg::CONF_W-1:0]    conf_o_q;
	logic                          fresh_o_q;

	// Combinational values.
	logic [CW-1:0]        weff;
	logic [LW-1:0]        minl;
	logic [LW-1:0]        maxl;
	logic [LW-1:0]        hi;
	logic [CW:0]          fill_p1;
	logic [CW-1:0]        n_next;
	logic [AW-1:0]        wp_next;
	logic [AW:0]          st_full;
	logic [AW-1:0]        start;
	logic [AW:0]          pb_full;
	logic [AW-1:0]        ptr_b_init;
	logic                 issue;
	logic [SB-1:0]        samp;
	logic signed [DVW-1:0] dev_a;
	logic signed [DVW-1:0] dev_b;
	logic signed [DVW-1:0] mul_b;
	logic signed [PW-1:0] prod_c;
	logic [MAGW-1:0]      mag;
	logic [MAGW-1:0]      mag_sh;
	logic [att_pkg::WIDX_W-1:0] widx;
	logic [PERW-1:0]      target;
	logic [PERW+18:0]     smooth_sum;
	logic [10:0]          conf_x3;
	logic [att_pkg::CONF_W-1:0] conf_calc;
	logic [NUMW-1:0]      div_num;
	logic [DENW-1:0]      div_den;
	logic                 div_done;
	logic [NUMW-1:0]      div_quot;
	logic [16:0]          q17;

	// Register limits and window geometry.
	always_comb begin
		if (cfg.window_hops == '0)
			weff = CW'(1);
		else if (16'(cfg.window_hops) > 16'(MAX_WINDOW))
			weff = CW'(MAX_WINDOW);
		else
			weff = CW'(cfg.window_hops);
		if (cfg.min_lag == '0)
			minl = LW'(1);
		else if (16'(cfg.min_lag) > 16'(MAX_LAG))
			minl = LW'(MAX_LAG);
		else
			minl = LW'(cfg.min_lag);
		if (16'(cfg.max_lag) > 16'(MAX_LAG))
			maxl = LW'(MAX_LAG);
		else
			maxl = LW'(cfg.max_lag);
		if (16'(maxl) < 16'(fill_q) - 16'd1)
			hi = maxl;
		else
			hi = LW'(fill_q - 1'b1);
		fill_p1 = {1'b0, fill_q} + 1'b1;
		n_next  = (fill_p1 > (CW+1)'(weff)) ? weff : CW'(fill_p1);
		wp_next = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
		st_full = {1'b0, wp_q} + (AW+1)'(MAX_WINDOW) - (AW+1)'(fill_q);
		start   = (st_full >= (AW+1)'(MAX_WINDOW)) ? AW'(st_full - (AW+1)'(MAX_WINDOW))
		                                            : AW'(st_full);
		pb_full = {1'b0, start} + (AW+1)'(lag_q);
		ptr_b_init = (pb_full >= (AW+1)'(MAX_WINDOW)) ? AW'(pb_full - (AW+1)'(MAX_WINDOW))
		                                               : AW'(pb_full);
		widx = (16'(lag_q) > 16'(att_pkg::WEIGHT_DEPTH - 1)) ? '1 : att_pkg::WIDX_W'(lag_q);
		samp = SB'(odf_sample);
	end

	// Samples or deviation products of the streaming pass.
	always_comb begin
		dev_a  = $signed({1'b0, rd_a_s1}) - $signed({1'b0, mean_q});
		dev_b  = $signed({1'b0, rd_b_s1}) - $signed({1'b0, mean_q});
		mul_b  = (kind_q == att_pkg::PASS_CORR) ? dev_b : dev_a;
		prod_c = (kind_q == att_pkg::PASS_SUM) ? $signed(PW'(rd_a_s1)) : dev_a * mul_b;
		issue  = (iss_cnt_q != len_q);
	end

	// Magnitude of the correlation scaled like the energy.
	always_comb begin
		mag    = acc_q[ACC_W-1] ? MAGW'($unsigned(-acc_q)) : MAGW'($unsigned(acc_q));
		mag_sh = mag >> sh_q;
		q17    = div_quot[16:0];
	end

	// Divider operand selection.
	always_comb begin
		case (cmd.div_sel)
			att_pkg::DIV_MEAN: begin
				div_num = NUMW'($unsigned(acc_q)) + NUMW'(fill_q >> 1);
				div_den = DENW'(fill_q);
			end
			att_pkg::DIV_NORM: begin
				div_num = {mag_sh[ESW-1:0], 16'd0};
				div_den = DENW'(es_q[ESW-1:0]);
			end
			att_pkg::DIV_TEMPO: begin
				div_num = NUMW'({cfg.bpm_numerator, 7'd0}) + NUMW'(period_q >> 1);
				div_den = DENW'(period_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	// Smoothing target and confidence.
	always_comb begin
		target = (16'(best_lag_q) > 16'(LAG_SAT)) ? PERIOD_MAX : PERW'({best_lag_q, 16'd0});
		smooth_sum = (PERW+19)'(mul1_q) + (PERW+19)'(mul2_q) + (PERW+19)'(32768);
		conf_x3 = 11'((19'(best_norm_q[16:0]) * 19'd3) >> 8);
		if (best_norm_q <= 0)
			conf_calc = '0;
		else if (conf_x3 > 11'd256)
			conf_calc = att_pkg::CONF_W'(256);
		else
			conf_calc = att_pkg::CONF_W'(conf_x3);
	end

	att_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q          <= '0;
			fill_q        <= '0;
			iss_cnt_q     <= '0;
			len_q         <= '0;
			v_s1_q        <= 1'b0;
			v_s2_q        <= 1'b0;
			have_period_q <= 1'b0;
			fresh_q       <= 1'b0;
			pend_q        <= 1'b0;
			have_best_q   <= 1'b0;
		end else begin
			if (cmd.accept_sample) begin
				wp_q    <= wp_next;
				fill_q  <= n_next;
				fresh_q <= 1'b0;
			end
			if (cmd.pass_start) begin
				iss_cnt_q <= '0;
				len_q     <= (cmd.kind == att_pkg::PASS_CORR) ? CW'(fill_q - CW'(lag_q)) : fill_q;
			end else if (issue) begin
				iss_cnt_q <= iss_cnt_q + 1'b1;
			end
			v_s1_q <= issue && !cmd.pass_start;
			v_s2_q <= v_s1_q;
			if (cmd.lag_init)
				have_best_q <= 1'b0;
			else if (cmd.compare_step)
				have_best_q <= 1'b1;
			if (cmd.smooth1) begin
				fresh_q       <= 1'b1;
				have_period_q <= 1'b1;
				pend_q        <= have_period_q;
			end
		end
	end

	// Window and weight memories.
	always_ff @(posedge clk) begin
		if (cmd.accept_sample)
			win_mem[wp_q] <= samp;
		rd_a_s1 <= win_mem[ptr_a_q];
		rd_b_s1 <= win_mem[ptr_b_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.write_weight)
			wt_mem[weight_index] <= weight_value;
		wt_q <= wt_mem[widx];
	end

	// Pass addressing, products and accumulation.
	always_ff @(posedge clk) begin
		if (cmd.pass_start) begin
			kind_q  <= cmd.kind;
			ptr_a_q <= start;
			ptr_b_q <= ptr_b_init;
		end else if (issue) begin
			ptr_a_q <= (ptr_a_q == AW'(MAX_WINDOW - 1)) ? '0 : ptr_a_q + 1'b1;
			ptr_b_q <= (ptr_b_q == AW'(MAX_WINDOW - 1)) ? '0 : ptr_b_q + 1'b1;
		end
		prod_s2 <= prod_c;
		if (cmd.pass_start)
			acc_q <= '0;
		else if (v_s2_q)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// Statistics, lag search, smoothing and result registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_mean)
			mean_q <= SB'(div_quot);
		if (cmd.energy_init) begin
			es_q <= MAGW'($unsigned(acc_q));
			sh_q <= '0;
		end else if (cmd.shift_step) begin
			es_q <= es_q >> 1;
			sh_q <= sh_q + 1'b1;
		end
		if (cmd.lag_init) begin
			lag_q       <= minl;
			best_lag_q  <= minl;
			best_norm_q <= '0;
		end else if (cmd.compare_step) begin
			lag_q <= lag_q + 1'b1;
			if (!have_best_q || score_q > best_score_q) begin
				best_score_q <= score_q;
				best_norm_q  <= norm_q;
				best_lag_q   <= lag_q;
			end
		end
		if (cmd.latch_norm)
			norm_q <= acc_q[ACC_W-1] ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
		if (cmd.score_mul)
			score_q <= norm_q * $signed({1'b0, wt_q});
		if (cmd.smooth1) begin
			if (!have_period_q)
				period_q <= target;
			mul1_q <= cfg.smoothing_alpha * period_q;
			mul2_q <= (17'h10000 - 17'(cfg.smoothing_alpha)) * target;
		end
		if (cmd.smooth2 && pend_q)
			period_q <= smooth_sum[PERW+15:16];
		if (cmd.tempo_zero)
			tempo_res_q <= '0;
		else if (cmd.latch_tempo)
			tempo_res_q <= (|div_quot[NUMW-1:16]) ? '1 : div_quot[15:0];
		if (cmd.load_out) begin
			tempo_o_q <= tempo_res_q;
			conf_o_q  <= fresh_q ? conf_calc : '0;
			fresh_o_q <= fresh_q;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.short_win   = (16'(fill_q) < (16'(maxl) << 1));
		sts.pass_done   = !issue && !v_s1_q && !v_s2_q;
		sts.div_done    = div_done;
		sts.energy_zero = (acc_q == '0);
		sts.shift_done  = (es_q < (MAGW'(1) << ESW));
		sts.lag_empty   = (16'(lag_q) > 16'(hi));
		sts.tempo_ok    = have_period_q && (period_q != '0);
	end

	assign tempo_bpm  = tempo_o_q;
	assign confidence = conf_o_q;
	assign fresh      = fresh_o_q;

	// The normalized correlation never exceeds one.
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_norm |-> (div_quot <= NUMW'(65536)))
		else $error("normalized correlation above one");

	// A transaction without a fresh estimate carries no confidence.
	a_conf_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load_out) && !fresh_o_q |-> (conf_o_q == '0))
		else $error("confidence without a fresh estimate");

	// Once a period exists it stays non-zero.
	a_period_nz: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.smooth2) && have_period_q |-> (period_q != '0))
		else $error("smoothed period collapsed to zero");

endmodule

// ----- hdl/att_ctrl.sv -----
// Controller state machine that sequences the tempo tracker datapath.
module att_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	output logic             out_valid,
	input  logic             out_ready,
	output att_pkg::cmd_t    cmd,
	input  att_pkg::status_t sts
);
	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_SUM,
		S_MEAN,
		S_ENERGY,
		S_SHIFT,
		S_NEXT,
		S_CORR,
		S_NORM,
		S_SCORE,
		S_CMP,
		S_SMOOTH1,
		S_SMOOTH2,
		S_TEMPO,
		S_TDIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Commands for the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.write_weight  = op;
					cmd.accept_sample = !op;
				end
			end
			S_CHECK: begin
				if (!sts.short_win) begin
					cmd.pass_start = 1'b1;
					cmd.kind       = att_pkg::PASS_SUM;
				end
			end
			S_SUM: begin
				if (sts.pass_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = att_pkg::DIV_MEAN;
				end
			end
			S_MEAN: begin
				cmd.div_sel = att_pkg::DIV_MEAN;
				if (sts.div_done) begin
					cmd.latch_mean = 1'b1;
					cmd.pass_start = 1'b1;
					cmd.kind       = att_pkg::PASS_ENERGY;
				end
			end
			S_ENERGY: begin
				if (sts.pass_done && !sts.energy_zero)
					cmd.energy_init = 1'b1;
			end
			S_SHIFT: begin
				if (sts.shift_done)
					cmd.lag_init = 1'b1;
				else
					cmd.shift_step = 1'b1;
			end
			S_NEXT: begin
				if (!sts.lag_empty) begin
					cmd.pass_start = 1'b1;
					cmd.kind       = att_pkg::PASS_CORR;
				end
			end
			S_CORR: begin
				if (sts.pass_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = att_pkg::DIV_NORM;
				end
			end
			S_NORM: begin
				cmd.div_sel = att_pkg::DIV_NORM;
				if (sts.div_done)
					cmd.latch_norm = 1'b1;
			end
			S_SCORE:   cmd.score_mul    = 1'b1;
			S_CMP:     cmd.compare_step = 1'b1;
			S_SMOOTH1: cmd.smooth1      = 1'b1;
			S_SMOOTH2: cmd.smooth2      = 1'b1;
			S_TEMPO: begin
				cmd.div_sel = att_pkg::DIV_TEMPO;
				if (sts.tempo_ok)
					cmd.div_start = 1'b1;
				else
					cmd.tempo_zero = 1'b1;
			end
			S_TDIV: begin
				cmd.div_sel = att_pkg::DIV_TEMPO;
				if (sts.div_done)
					cmd.latch_tempo = 1'b1;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready)
					cmd.load_out = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	// State and the output valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:    if (cmd.accept_sample) state_q <= S_CHECK;
				S_CHECK:   state_q <= sts.short_win ? S_TEMPO : S_SUM;
				S_SUM:     if (sts.pass_done) state_q <= S_MEAN;
				S_MEAN:    if (sts.div_done) state_q <= S_ENERGY;
				S_ENERGY: begin
					if (sts.pass_done)
						state_q <= sts.energy_zero ? S_TEMPO : S_SHIFT;
				end
				S_SHIFT:   if (sts.shift_done) state_q <= S_NEXT;
				S_NEXT:    state_q <= sts.lag_empty ? S_SMOOTH1 : S_CORR;
				S_CORR:    if (sts.pass_done) state_q <= S_NORM;
				S_NORM:    if (sts.div_done) state_q <= S_SCORE;
				S_SCORE:   state_q <= S_CMP;
				S_CMP:     state_q <= S_NEXT;
				S_SMOOTH1: state_q <= S_SMOOTH2;
				S_SMOOTH2: state_q <= S_TEMPO;
				S_TEMPO:   state_q <= sts.tempo_ok ? S_TDIV : S_OUT;
				S_TDIV:    if (sts.div_done) state_q <= S_OUT;
				S_OUT:     if (cmd.load_out) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	// Every accepted sample is followed by the window check.
	a_sample_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept_sample |=> (state_q == S_CHECK))
		else $error("sample transaction not followed by the window check");

	// A weight write returns straight to idle.
	a_weight_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_weight |=> in_ready)
		else $error("weight write did not return to idle");

endmodule

// ----- hdl/autocorrelation_tempo_tracker.sv -----
// Top level of the autocorrelation tempo tracker with its register port.
//
//  Channel   Handshake                     Moves
//  config    psel/penable/pwrite/pready    register write or read, 32 bits
//  in        in_valid/in_ready             op, odf_sample, weight_index, weight_value
//  out       out_valid/out_ready           tempo_bpm, confidence, fresh
//
// A weight write goes straight back to idle. A short window only runs the tempo step, or a
// zero before the first period exists. A flat window runs a sum pass, the mean division and
// an energy pass before the tempo step; a full estimate adds the energy shifts and, per lag,
// a single correlation pass, a normalizing division, a score and a compare, then smoothing
// and the tempo division, over the two read ports of the window memory and the shared divider.
// Reset clears the control state and sets the configuration registers; there is no clearing pass.
// A waiting result stalls the block only when the next result is ready.
module autocorrelation_tempo_tracker #(
	parameter int MAX_WINDOW  = att_pkg::MAX_WINDOW_DEF,
	parameter int MAX_LAG     = att_pkg::MAX_LAG_DEF,
	parameter int SAMPLE_BITS = att_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [att_pkg::ODF_W-1:0]     odf_sample,
	input  logic [att_pkg::WIDX_W-1:0]    weight_index,
	input  logic [att_pkg::WEIGHT_W-1:0]  weight_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [att_pkg::TEMPO_W-1:0]   tempo_bpm,
	output logic [att_pkg::CONF_W-1:0]    confidence,
	output logic                          fresh
);
	localparam logic [2:0] REG_WINDOW_HOPS = 3'd0;
	localparam logic [2:0] REG_MIN_LAG     = 3'd1;
	localparam logic [2:0] REG_MAX_LAG     = 3'd2;
	localparam logic [2:0] REG_BPM_NUM     = 3'd3;
	localparam logic [2:0] REG_ALPHA       = 3'd4;

	att_pkg::cfg_t    cfg_q;
	att_pkg::cmd_t    cmd;
	att_pkg::status_t sts;
	logic [2:0]       reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_hops     <= att_pkg::WINDOW_HOPS_RST;
			cfg_q.min_lag         <= att_pkg::MIN_LAG_RST;
			cfg_q.max_lag         <= att_pkg::MAX_LAG_RST;
			cfg_q.bpm_numerator   <= att_pkg::BPM_NUM_RST;
			cfg_q.smoothing_alpha <= att_pkg::ALPHA_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WINDOW_HOPS: cfg_q.window_hops     <= pwdata[10:0];
				REG_MIN_LAG:     cfg_q.min_lag         <= pwdata[8:0];
				REG_MAX_LAG:     cfg_q.max_lag         <= pwdata[8:0];
				REG_BPM_NUM:     cfg_q.bpm_numerator   <= pwdata;
				REG_ALPHA:       cfg_q.smoothing_alpha <= pwdata[15:0];
				default:         cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_WINDOW_HOPS: prdata = 32'(cfg_q.window_hops);
			REG_MIN_LAG:     prdata = 32'(cfg_q.min_lag);
			REG_MAX_LAG:     prdata = 32'(cfg_q.max_lag);
			REG_BPM_NUM:     prdata = cfg_q.bpm_numerator;
			REG_ALPHA:       prdata = 32'(cfg_q.smoothing_alpha);
			default:         prdata = '0;
		endcase
	end

	att_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	att_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.MAX_LAG     (MAX_LAG),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.odf_sample   (odf_sample),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.tempo_bpm    (tempo_bpm),
		.confidence   (confidence),
		.fresh        (fresh)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the autocorrelation tempo tracker.
module tb_top;

	// Register indexes of the configuration port.
	localparam int REG_WINDOW_HOPS = 0;
	localparam int REG_MIN_LAG     = 1;
	localparam int REG_MAX_LAG     = 2;
	localparam int REG_BPM_NUM     = 3;
	localparam int REG_ALPHA       = 4;

	// Input operations.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	localparam int WIN_DEPTH     = 1024;
	localparam int LAG_LIMIT     = 256;
	localparam int WEIGHT_LOAD   = 24;
	localparam int REPORT_DEPTH  = 256;
	localparam int SETTLE_CYCLES = 3000;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [att_pkg::TEMPO_W-1:0] tempo;
		logic [att_pkg::CONF_W-1:0]  conf;
		logic                        fresh;
	} tempo_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = OP_SAMPLE;
	logic [att_pkg::ODF_W-1:0] odf_sample = '0;
	logic [att_pkg::WIDX_W-1:0] weight_index = '0;
	logic [att_pkg::WEIGHT_W-1:0] weight_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [att_pkg::TEMPO_W-1:0] tempo_bpm;
	logic [att_pkg::CONF_W-1:0] confidence;
	logic fresh;

	autocorrelation_tempo_tracker u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.odf_sample(odf_sample), .weight_index(weight_index),
		.weight_value(weight_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.tempo_bpm(tempo_bpm), .confidence(confidence), .fresh(fresh)
	);

	always #5 clk = ~clk;

	// Tracker state mirrored by the testbench.
	logic [15:0] hist_mem [WIN_DEPTH];
	logic [15:0] octave_wt [256];
	int unsigned hist_fill, hist_wr;
	longint unsigned period_q16;
	bit period_valid;
	longint deviation [WIN_DEPTH];
	int unsigned cfg_window, cfg_min_lag, cfg_max_lag;
	longint unsigned cfg_bpm, cfg_alpha;

	// Expected reports, oldest at rep_head.
	tempo_report_t report_fifo [REPORT_DEPTH];
	int unsigned rep_head = 0, rep_tail = 0;
	int unsigned mismatches = 0;
	int unsigned gap_pct = 0, stall_pct = 0;
	longint cycle_count = 0;

	function automatic void queue_report(input tempo_report_t rep);
		report_fifo[rep_tail % REPORT_DEPTH] = rep;
		rep_tail++;
	endfunction

	function automatic longint unsigned current_tempo();
		longint unsigned q;
		if (!period_valid || period_q16 == 0) return 0;
		q = (cfg_bpm * 128 + period_q16 / 2) / period_q16;
		return (q > 65535) ? 65535 : q;
	endfunction

	// Works out the report that one accepted transaction should cause.
	task automatic predict_tempo(input logic is_weight, input logic [15:0] sample,
			input logic [7:0] idx, input logic [15:0] wval);
		int unsigned weff, n, minl, maxl, hi, start, sh, win_lag, wi;
		longint unsigned sum, mean, energy, es, target, mag, conf;
		longint c, norm, score, best_score, best_norm;
		bit have_best;
		tempo_report_t rep;
		if (is_weight) begin
			octave_wt[idx] = wval;
			return;
		end
		hist_mem[hist_wr] = sample;
		hist_wr = (hist_wr + 1) % WIN_DEPTH;
		weff = (cfg_window == 0) ? 1 : (cfg_window > WIN_DEPTH ? WIN_DEPTH : cfg_window);
		hist_fill = (hist_fill + 1 > weff) ? weff : hist_fill + 1;
		n = hist_fill;
		minl = (cfg_min_lag < 1) ? 1 : (cfg_min_lag > LAG_LIMIT ? LAG_LIMIT : cfg_min_lag);
		maxl = (cfg_max_lag > LAG_LIMIT) ? LAG_LIMIT : cfg_max_lag;
		rep.tempo = 16'(current_tempo());
		rep.conf = '0;
		rep.fresh = 1'b0;
		if (n < 2 * maxl) begin
			queue_report(rep);
			return;
		end
		// Mean removal and window energy.
		start = (hist_wr + WIN_DEPTH - n) % WIN_DEPTH;
		sum = 0;
		for (int i = 0; i < n; i++) sum += hist_mem[(start + i) % WIN_DEPTH];
		mean = (sum + n / 2) / n;
		energy = 0;
		for (int i = 0; i < n; i++) begin
			deviation[i] = longint'(hist_mem[(start + i) % WIN_DEPTH]) - longint'(mean);
			energy += longint'(deviation[i] * deviation[i]);
		end
		if (energy == 0) begin
			queue_report(rep);
			return;
		end
		sh = 0;
		while ((energy >> sh) >= (64'd1 << 40)) sh++;
		es = energy >> sh;
		// Weighted lag search; the first best lag wins.
		win_lag = minl;
		best_score = 0;
		best_norm = 0;
		have_best = 0;
		hi = (maxl < n - 1) ? maxl : n - 1;
		for (int lag = minl; lag <= hi; lag++) begin
			c = 0;
			for (int i = 0; i + lag < n; i++) c += deviation[i] * deviation[i + lag];
			mag = (c < 0) ? longint'(-c) : longint'(c);
			norm = longint'(((mag >> sh) << 16) / es);
			if (c < 0) norm = -norm;
			wi = (lag > 255) ? 255 : lag;
			score = norm * longint'(octave_wt[wi]);
			if (!have_best || score > best_score) begin
				have_best = 1;
				best_score = score;
				best_norm = norm;
				win_lag = lag;
			end
		end
		// Period smoothing.
		target = longint'(win_lag) << 16;
		if (target > 64'h1FFFFFF) target = 64'h1FFFFFF;
		if (!period_valid) begin
			period_q16 = target;
			period_valid = 1;
		end else begin
			period_q16 = ((cfg_alpha * period_q16 + (65536 - cfg_alpha) * target + 32768)
				>> 16) & 64'h1FFFFFF;
		end
		if (best_norm <= 0) conf = 0;
		else begin
			conf = (longint'(best_norm) * 3) >> 8;
			if (conf > 256) conf = 256;
		end
		rep.tempo = 16'(current_tempo());
		rep.conf = 9'(conf);
		rep.fresh = 1'b1;
		queue_report(rep);
	endtask

	// Sends one transaction; entered and left at a falling edge.
	task automatic send_item(input logic is_weight, input logic [15:0] sample,
			input logic [7:0] idx, input logic [15:0] wval);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= is_weight;
		odf_sample <= sample;
		weight_index <= idx;
		weight_value <= wval;
		do @(posedge clk); while (!in_ready);
		predict_tempo(is_weight, sample, idx, wval);
		@(negedge clk);
	endtask

	task automatic send_sample(input logic [15:0] sample);
		send_item(OP_SAMPLE, sample, 8'($urandom_range(255)), 16'($urandom_range(65535)));
	endtask

	// Waits until every report has arrived and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (rep_tail != rep_head) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW_HOPS: cfg_window = value[10:0];
			REG_MIN_LAG:     cfg_min_lag = value[8:0];
			REG_MAX_LAG:     cfg_max_lag = value[8:0];
			REG_BPM_NUM:     cfg_bpm = value;
			REG_ALPHA:       cfg_alpha = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int unsigned win, input int unsigned minl,
			input int unsigned maxl, input logic [31:0] bpm, input logic [15:0] alpha);
		write_reg(REG_WINDOW_HOPS, win);
		write_reg(REG_MIN_LAG, minl);
		write_reg(REG_MAX_LAG, maxl);
		write_reg(REG_BPM_NUM, bpm);
		write_reg(REG_ALPHA, alpha);
	endtask

	// Every entry that the tested lag ranges can reach is written first.
	task automatic test_weight_load();
		for (int i = 0; i < WEIGHT_LOAD; i++)
			send_item(OP_WEIGHT, 16'($urandom_range(65535)), 8'(i),
				(i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom_range(65535)));
	endtask

	// Reset settings: the window is far too short, so tempo stays at zero.
	task automatic test_short_window();
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		drain();
	endtask

	// Small window with extreme numerator and no smoothing.
	task automatic test_directed_estimates();
		set_config(8, 0, 3, 32'hFFFFFFFF, 16'h0000);
		for (int i = 0; i < 10; i++) send_sample((i % 3 == 0) ? 16'hFFFF : 16'h0000);
		drain();
		// Full smoothing and a zero numerator.
		set_config(6, 2, 3, 32'h0, 16'hFFFF);
		for (int i = 0; i < 4; i++) send_sample((i % 2) ? 16'h1234 : 16'hFEDC);
		drain();
	endtask

	// Constant samples leave no energy once the mean is removed.
	task automatic test_flat_window();
		set_config(4, 1, 2, 32'd338690048, 16'd65031);
		for (int i = 0; i < 6; i++) send_sample(16'h4321);
		drain();
	endtask

	// Lag bounds that leave nothing to search, and windows out of range.
	task automatic test_range_limits();
		set_config(8, 511, 0, 32'd338690048, 16'd30000);
		send_sample(16'h0100);
		send_sample(16'hF000);
		send_sample(16'h0001);
		drain();
		set_config(0, 1, 0, 32'd338690048, 16'd30000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		drain();
		set_config(2047, 0, 511, 32'd338690048, 16'd30000);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		drain();
	endtask

	// Random pulse trains and weight writes under the given input gaps and receiver stalls.
	task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
			input int count);
		int unsigned win, pulse_period;
		logic [15:0] s;
		win = $urandom_range(2, 40);
		set_config(win, $urandom_range(0, 12), $urandom_range(0, win / 2),
			$urandom, 16'($urandom_range(65535)));
		gap_pct = gap;
		stall_pct = stall;
		pulse_period = $urandom_range(2, 9);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0)
				send_item(OP_WEIGHT, 16'($urandom_range(65535)), 8'($urandom_range(255)),
					16'($urandom_range(65535)));
			else begin
				if ($urandom_range(5) == 0) s = 16'($urandom_range(65535));
				else if (k % pulse_period == 0) s = 16'($urandom_range(30000, 65535));
				else s = 16'($urandom_range(0, 4000));
				send_sample(s);
			end
		end
		drain();
		gap_pct = 0;
		stall_pct = 0;
	endtask

	// Receiver back-pressure.
	always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	// Compare each report with the oldest expectation.
	always @(posedge clk) begin
		tempo_report_t exp_rep;
		if (arst_n && out_valid && out_ready) begin
			if (rep_tail == rep_head) begin
				$display("%0t unexpected report: tempo %0d conf %0d fresh %0d",
					$time, tempo_bpm, confidence, fresh);
				mismatches++;
			end else begin
				exp_rep = report_fifo[rep_head % REPORT_DEPTH];
				rep_head++;
				if (tempo_bpm !== exp_rep.tempo) begin
					$display("%0t tempo_bpm expected %0d actual %0d",
						$time, exp_rep.tempo, tempo_bpm);
					mismatches++;
				end
				if (confidence !== exp_rep.conf) begin
					$display("%0t confidence expected %0d actual %0d",
						$time, exp_rep.conf, confidence);
					mismatches++;
				end
				if (fresh !== exp_rep.fresh) begin
					$display("%0t fresh expected %0d actual %0d",
						$time, exp_rep.fresh, fresh);
					mismatches++;
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("autocorrelation_tempo_tracker regression: fail");
			$finish;
		end
	end

	initial begin
		cfg_window = att_pkg::WINDOW_HOPS_RST;
		cfg_min_lag = att_pkg::MIN_LAG_RST;
		cfg_max_lag = att_pkg::MAX_LAG_RST;
		cfg_bpm = att_pkg::BPM_NUM_RST;
		cfg_alpha = att_pkg::ALPHA_RST;
		hist_fill = 0;
		hist_wr = 0;
		period_q16 = 0;
		period_valid = 0;
		for (int i = 0; i < WIN_DEPTH; i++) hist_mem[i] = '0;
		for (int i = 0; i < 256; i++) octave_wt[i] = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_weight_load();
		test_short_window();
		test_directed_estimates();
		test_flat_window();
		test_range_limits();
		test_random_traffic(0, 0, 15);
		test_random_traffic(72, 0, 15);
		test_random_traffic(0, 72, 15);
		test_random_traffic(30, 30, 15);
		if (mismatches == 0)
			$display("autocorrelation_tempo_tracker regression: pass");
		else
			$display("autocorrelation_tempo_tracker regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/att_pkg.sv
hdl/att_divider.sv
hdl/att_datapath.sv
hdl/att_ctrl.sv
hdl/autocorrelation_tempo_tracker.sv
tb/tb_top.sv
